/* hw/rtl/btf_pkg.sv */
// shared types, constants and helpers for the breadcrumb trail follower
// no dependencies; imported by every module of the block but btf_ram
package btf_pkg;

  localparam int TRAIL_DEPTH   = 64;
  localparam int IDX_W         = $clog2(TRAIL_DEPTH);
  localparam int CNT_W         = $clog2(TRAIL_DEPTH + 1);
  localparam int POS_W         = 24;
  localparam int DIFF_W        = POS_W + 1;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int SUM_W         = SQ_W + 1;
  localparam int THR_W         = 16;
  localparam int THR2_W        = 2 * THR_W;
  localparam int HEAD_W        = 16;
  localparam int CORDIC_STEPS  = 20;
  localparam int STEP_W        = 5;
  localparam int CX_W          = DIFF_W + 3;
  localparam int ANG_W         = 23;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = THR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR    = 2'd1;
  localparam logic [THR_W-1:0]     FD_RESET        = 16'd1250;
  localparam logic [THR_W-1:0]     ST_RESET        = 16'd100;
  localparam logic signed [ANG_W-1:0] ANG_PI       = 23'sd1048576;

  typedef enum logic [4:0] {
    S_IDLE, S_SEED, S_SQF, S_SQS, S_RDN, S_LDN, S_PHS, S_PHW, S_DX, S_DY,
    S_STEP, S_RDO, S_LDO, S_PDX, S_PDY, S_PCMP, S_GHS, S_GHW, S_OUT
  } state_t;

  typedef enum logic [1:0] {SQ_FD, SQ_ST, SQ_DX, SQ_DY} sq_sel_t;
  typedef enum logic {HD_PERSON, HD_GOAL} hd_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    seed;
    sq_sel_t sq_sel;
    logic    ld_fd2;
    logic    ld_st2;
    logic    ld_sqa;
    logic    ld_sqb;
    logic    rd_newest;
    logic    rd_oldest;
    logic    ld_entry;
    logic    hd_start;
    hd_sel_t hd_sel;
    logic    ld_phead;
    logic    append;
    logic    drop;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic cnt_zero;
    logic cnt_gt1;
    logic gt_step;
    logic gt_follow;
    logic hd_busy;
    logic out_free;
  } sts_t;

  // arctangent table, pi = 2^20
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = 23'sd262144;
      5'd1:    v = 23'sd154753;
      5'd2:    v = 23'sd81767;
      5'd3:    v = 23'sd41506;
      5'd4:    v = 23'sd20834;
      5'd5:    v = 23'sd10427;
      5'd6:    v = 23'sd5215;
      5'd7:    v = 23'sd2608;
      5'd8:    v = 23'sd1304;
      5'd9:    v = 23'sd652;
      5'd10:   v = 23'sd326;
      5'd11:   v = 23'sd163;
      5'd12:   v = 23'sd81;
      5'd13:   v = 23'sd41;
      5'd14:   v = 23'sd20;
      5'd15:   v = 23'sd10;
      5'd16:   v = 23'sd5;
      5'd17:   v = 23'sd3;
      5'd18:   v = 23'sd1;
      5'd19:   v = 23'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // ring index wrap, input below twice the depth
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
    logic [IDX_W:0] t;
    if (s >= (IDX_W+1)'(TRAIL_DEPTH)) begin
      t = s - (IDX_W+1)'(TRAIL_DEPTH);
    end else begin
      t = s;
    end
    return t[IDX_W-1:0];
  endfunction

endpackage

/* hw/rtl/btf_ram.sv */
// generic single-port ram with registered read
// no dependencies
module btf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hw/rtl/btf_cordic.sv */
// iterative vectoring cordic, one step per cycle, gives atan2 with pi = 32768
// depends on btf_pkg
module btf_cordic import btf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] x_in,
  input  logic signed [DIFF_W-1:0] y_in,
  output logic                     busy,
  output logic [HEAD_W-1:0]        heading
);

  logic signed [CX_W-1:0]  x_r, x_nxt, y_r, y_nxt, xs, ys, xe, ye;
  logic signed [ANG_W-1:0] z_r, z_nxt, zr;
  logic [STEP_W-1:0]       i_r, i_nxt;
  logic                    busy_r, busy_nxt, zero_r, zero_nxt;

  always_comb begin
    xe = CX_W'(x_in);
    ye = CX_W'(y_in);
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    if (start) begin
      zero_nxt = (x_in == '0) && (y_in == '0);
      i_nxt = '0;
      busy_nxt = 1'b1;
      // left half plane: turn by pi first
      if (x_in < 0) begin
        x_nxt = -xe;
        y_nxt = -ye;
        z_nxt = (y_in >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        x_nxt = xe;
        y_nxt = ye;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_entry(i_r);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_entry(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    i_r    <= i_nxt;
    zero_r <= zero_nxt;
  end

  assign zr      = z_r + ANG_W'(16);
  assign busy    = busy_r;
  assign heading = zero_r ? '0 : zr[HEAD_W+4:5];

endmodule

/* hw/rtl/btf_datapath.sv */
// trail storage, squared-distance unit, heading unit and result register
// depends on btf_pkg, btf_ram, btf_cordic
module btf_datapath import btf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic signed [POS_W-1:0] in_person_x,
  input  logic signed [POS_W-1:0] in_person_y,
  input  logic signed [POS_W-1:0] in_robot_x,
  input  logic signed [POS_W-1:0] in_robot_y,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic                    out_goal_valid,
  output logic signed [POS_W-1:0] out_goal_x,
  output logic signed [POS_W-1:0] out_goal_y,
  output logic signed [HEAD_W-1:0] out_goal_heading,
  output logic signed [HEAD_W-1:0] out_person_heading,
  output logic                    out_point_appended,
  output logic                    out_trail_overflow
);

  logic [THR_W-1:0]        fd_r, st_r;
  logic [THR2_W-1:0]       fd2_r, st2_r;
  logic signed [POS_W-1:0] px_r, py_r, rx_r, ry_r, ex_r, ey_r;
  logic [IDX_W-1:0]        oldest_r, oldest_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    started_r, started_nxt, seed_r;
  logic                    app_r, ovf_r;
  logic [SQ_W-1:0]         sqa_r, sqb_r, sq;
  logic [SUM_W-1:0]        sum;
  logic [HEAD_W-1:0]       ph_r, hd;
  logic                    out_valid_r;
  logic                    full;
  logic [IDX_W-1:0]        newest, tail, inc, addr;
  logic signed [DIFF_W-1:0] dx, dy, sd, hx, hy;
  logic [DIFF_W-1:0]       mag;
  logic                    hd_busy, ram_we;
  logic [2*POS_W-1:0]      rdata, wdata;

  // ring positions
  assign newest = wrap_idx({1'b0, oldest_r} + {1'b0, IDX_W'(count_r - CNT_W'(1))});
  assign tail   = wrap_idx({1'b0, oldest_r} + {1'b0, IDX_W'(count_r)});
  assign inc    = wrap_idx({1'b0, oldest_r} + (IDX_W+1)'(1));
  assign full   = count_r >= CNT_W'(TRAIL_DEPTH);

  assign dx = DIFF_W'(px_r) - DIFF_W'(ex_r);
  assign dy = DIFF_W'(py_r) - DIFF_W'(ey_r);

  always_comb begin
    case (cmd.sq_sel)
      SQ_FD:   sd = DIFF_W'(signed'({1'b0, fd_r}));
      SQ_ST:   sd = DIFF_W'(signed'({1'b0, st_r}));
      SQ_DX:   sd = dx;
      SQ_DY:   sd = dy;
      default: sd = '0;
    endcase
    mag = sd[DIFF_W-1] ? DIFF_W'(-sd) : DIFF_W'(sd);
  end

  assign sq  = SQ_W'(mag) * SQ_W'(mag);
  assign sum = {1'b0, sqa_r} + {1'b0, sqb_r};

  // trail ram address
  always_comb begin
    ram_we = cmd.seed | cmd.append;
    wdata  = {px_r, py_r};
    if (cmd.seed) begin
      addr = '0;
    end else if (cmd.append) begin
      addr = full ? oldest_r : tail;
    end else if (cmd.rd_newest) begin
      addr = newest;
    end else begin
      addr = oldest_r;
    end
  end

  btf_ram #(.WIDTH(2*POS_W), .DEPTH(TRAIL_DEPTH)) u_trail (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.rd_newest | cmd.rd_oldest),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_comb begin
    if (cmd.hd_sel == HD_PERSON) begin
      hx = dx;
      hy = dy;
    end else begin
      hx = DIFF_W'(ex_r) - DIFF_W'(rx_r);
      hy = DIFF_W'(ey_r) - DIFF_W'(ry_r);
    end
  end

  btf_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.hd_start),
    .x_in    (hx),
    .y_in    (hy),
    .busy    (hd_busy),
    .heading (hd)
  );

  // trail bookkeeping
  always_comb begin
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    started_nxt = started_r;
    if (cmd.seed) begin
      oldest_nxt  = '0;
      count_nxt   = CNT_W'(1);
      started_nxt = 1'b1;
    end else if (cmd.append) begin
      if (full) begin
        oldest_nxt = inc;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (cmd.drop) begin
      oldest_nxt = inc;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r        <= FD_RESET;
      st_r        <= ST_RESET;
      oldest_r    <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FOLLOW_DIST) begin
        fd_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_STEP_THR) begin
        st_r <= cfg_wdata;
      end
      oldest_r  <= oldest_nxt;
      count_r   <= count_nxt;
      started_r <= started_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      px_r   <= in_person_x;
      py_r   <= in_person_y;
      rx_r   <= in_robot_x;
      ry_r   <= in_robot_y;
      seed_r <= 1'b0;
      app_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end
    if (cmd.seed) begin
      seed_r <= 1'b1;
    end
    if (cmd.append) begin
      app_r <= 1'b1;
      ovf_r <= full;
    end
    if (cmd.ld_fd2) begin
      fd2_r <= sq[THR2_W-1:0];
    end
    if (cmd.ld_st2) begin
      st2_r <= sq[THR2_W-1:0];
    end
    if (cmd.ld_sqa) begin
      sqa_r <= sq;
    end
    if (cmd.ld_sqb) begin
      sqb_r <= sq;
    end
    if (cmd.ld_entry) begin
      ex_r <= rdata[2*POS_W-1:POS_W];
      ey_r <= rdata[POS_W-1:0];
    end
    if (cmd.ld_phead) begin
      ph_r <= hd;
    end
    if (cmd.out_load) begin
      // seeding word reports all zero
      out_goal_valid     <= !seed_r;
      out_goal_x         <= seed_r ? '0 : ex_r;
      out_goal_y         <= seed_r ? '0 : ey_r;
      out_goal_heading   <= seed_r ? '0 : hd;
      out_person_heading <= seed_r ? '0 : ph_r;
      out_point_appended <= seed_r ? 1'b0 : app_r;
      out_trail_overflow <= seed_r ? 1'b0 : ovf_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.started   = started_r;
    sts.cnt_zero  = count_r == '0;
    sts.cnt_gt1   = count_r > CNT_W'(1);
    sts.gt_step   = sum > SUM_W'(st2_r);
    sts.gt_follow = sum > SUM_W'(fd2_r);
    sts.hd_busy   = hd_busy;
    sts.out_free  = !out_valid_r || !out_stall;
  end

endmodule

/* hw/rtl/btf_ctrl.sv */
// sequencer for one item: thresholds, append test, drop walk, headings
// depends on btf_pkg
module btf_ctrl import btf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.started ? S_SQF : S_SEED;
        end
      end
      S_SEED: state_nxt = S_OUT;
      S_SQF:  state_nxt = S_SQS;
      S_SQS:  state_nxt = S_RDN;
      S_RDN:  state_nxt = S_LDN;
      S_LDN:  state_nxt = S_PHS;
      S_PHS:  state_nxt = S_PHW;
      S_PHW: begin
        if (!sts.hd_busy) begin
          state_nxt = S_DX;
        end
      end
      S_DX:   state_nxt = S_DY;
      S_DY:   state_nxt = S_STEP;
      S_STEP: state_nxt = S_RDO;
      S_RDO:  state_nxt = S_LDO;
      S_LDO:  state_nxt = sts.cnt_gt1 ? S_PDX : S_GHS;
      S_PDX:  state_nxt = S_PDY;
      S_PDY:  state_nxt = S_PCMP;
      S_PCMP: state_nxt = sts.gt_follow ? S_RDO : S_GHS;
      S_GHS:  state_nxt = S_GHW;
      S_GHW: begin
        if (!sts.hd_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = state_r != S_IDLE;
    case (state_r)
      S_IDLE: cmd.latch_in = in_valid;
      S_SEED: cmd.seed = 1'b1;
      S_SQF: begin
        cmd.sq_sel = SQ_FD;
        cmd.ld_fd2 = 1'b1;
      end
      S_SQS: begin
        cmd.sq_sel = SQ_ST;
        cmd.ld_st2 = 1'b1;
      end
      S_RDN:  cmd.rd_newest = 1'b1;
      S_LDN:  cmd.ld_entry = 1'b1;
      S_PHS: begin
        cmd.hd_start = 1'b1;
        cmd.hd_sel   = HD_PERSON;
      end
      S_PHW:  cmd.ld_phead = !sts.hd_busy;
      S_DX, S_PDX: begin
        cmd.sq_sel = SQ_DX;
        cmd.ld_sqa = 1'b1;
      end
      S_DY, S_PDY: begin
        cmd.sq_sel = SQ_DY;
        cmd.ld_sqb = 1'b1;
      end
      S_STEP: cmd.append = sts.gt_step;
      S_RDO:  cmd.rd_oldest = 1'b1;
      S_LDO:  cmd.ld_entry = 1'b1;
      S_PCMP: cmd.drop = sts.gt_follow;
      S_GHS: begin
        cmd.hd_start = 1'b1;
        cmd.hd_sel   = HD_GOAL;
      end
      S_GHW:  cmd.hd_sel = HD_GOAL;
      S_OUT:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/breadcrumb_trail_follower.sv */
// breadcrumb trail follower: person-following goal from a ring-buffer trail
// Input channel in_*: person and robot positions (24-bit signed mm). One result
// word per input word on out_*: goal, headings and trail flags.
// Config port cfg_*: index 0 follow distance, 1 step threshold; write only
// while idle. Reset values 1250 mm and 100 mm.
// Items are taken one at a time; in_stall is high from acceptance until the
// result is loaded into the output register, which then waits on out_stall
// while the next word is already accepted.
// Steps after acceptance: a seeding word goes from the seed state straight to
// the output load. Other words square both thresholds, read the newest entry,
// take the person heading, run the append test, walk the drop loop and take the
// goal heading: two 20-step cordic passes and the drop walk, which reads one
// trail entry and squares two differences on a shared multiplier per entry.
// A new word is accepted only after the last result is loaded; a stalled result
// holds the output register and delays the next load, not the next acceptance.
// Reset empties the trail; the first word afterwards seeds it and reports
// all zero fields. No clearing pass is needed.
// Depends on btf_pkg, btf_ctrl, btf_datapath.
module breadcrumb_trail_follower import btf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [POS_W-1:0]  in_person_x,
  input  logic signed [POS_W-1:0]  in_person_y,
  input  logic signed [POS_W-1:0]  in_robot_x,
  input  logic signed [POS_W-1:0]  in_robot_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_goal_valid,
  output logic signed [POS_W-1:0]  out_goal_x,
  output logic signed [POS_W-1:0]  out_goal_y,
  output logic signed [HEAD_W-1:0] out_goal_heading,
  output logic signed [HEAD_W-1:0] out_person_heading,
  output logic                     out_point_appended,
  output logic                     out_trail_overflow
);

  cmd_t cmd;
  sts_t sts;

  btf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  btf_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_person_x        (in_person_x),
    .in_person_y        (in_person_y),
    .in_robot_x         (in_robot_x),
    .in_robot_y         (in_robot_y),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_goal_valid     (out_goal_valid),
    .out_goal_x         (out_goal_x),
    .out_goal_y         (out_goal_y),
    .out_goal_heading   (out_goal_heading),
    .out_person_heading (out_person_heading),
    .out_point_appended (out_point_appended),
    .out_trail_overflow (out_trail_overflow)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in flight");

  a_seed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_goal_valid |-> out_goal_x == '0 && out_goal_y == '0 &&
      !out_point_appended && !out_trail_overflow)
    else $error("seeding word carries non-zero fields");

  a_ovf_needs_append: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trail_overflow |-> out_point_appended)
    else $error("overflow reported without an append");

  a_trail_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    sts.started |-> !sts.cnt_zero)
    else $error("seeded trail went empty");

endmodule
